[design/kfd_pkg.sv]
// Shared types and constants of the KISS frame deframer.
// Used by kfd_in_reg, kfd_engine, kiss_frame_deframer and kfd_checker.
package kfd_pkg;

  // Framing characters
  localparam logic [7:0] CH_FEND  = 8'd192;
  localparam logic [7:0] CH_FESC  = 8'd219;
  localparam logic [7:0] CH_TFEND = 8'd220;
  localparam logic [7:0] CH_TFESC = 8'd221;

  // Field widths
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CMD_W   = 4;
  localparam int unsigned MINLEN_W = 10;
  localparam int unsigned TICKS_W = 16;
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;
  localparam logic [MINLEN_W-1:0]  MIN_FRAME_LEN_RST = 10'd15;
  localparam logic [TICKS_W-1:0]   TIMEOUT_TICKS_RST = 16'd2000;

  // Default frame buffer length
  localparam int unsigned FRAME_BUF_LEN_DEF = 512;

  // Request types
  localparam logic [REQ_W-1:0] REQ_BYTE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ERR  = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_DATA    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GOOD    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SHORT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CMD     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LINE    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd5;

  // One result of the engine
  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [CMD_W-1:0]  command_code;
    logic [BYTE_W-1:0] first_value;
    logic [BYTE_W-1:0] second_value;
  } kfd_res_t;

endpackage

[design/kfd_in_reg.sv]
// Input register of the KISS frame deframer: holds one incoming transaction.
// Depends on kfd_pkg.
module kfd_in_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [kfd_pkg::S_TDATA_W-1:0] s_axis_tdata,  // rx_byte
  input  logic [kfd_pkg::REQ_W-1:0]  s_axis_tuser,      // req_type
  input  logic                       advance_i,
  output logic                       item_valid_o,
  output logic [kfd_pkg::REQ_W-1:0]  req_type_o,
  output logic [kfd_pkg::BYTE_W-1:0] rx_byte_o
);
  import kfd_pkg::*;

  logic              valid_q, valid_d;
  logic [REQ_W-1:0]  req_q;
  logic [BYTE_W-1:0] byte_q;
  logic              take;

  // Accept when empty or when the held item moves on this cycle
  assign s_axis_tready = !valid_q || advance_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q  <= s_axis_tuser;
      byte_q <= s_axis_tdata[BYTE_W-1:0];
    end
  end

  assign item_valid_o = valid_q;
  assign req_type_o   = req_q;
  assign rx_byte_o    = byte_q;

endmodule

[design/kfd_engine.sv]
// Deframing state and next-state logic of the KISS frame deframer.
// Depends on kfd_pkg.
module kfd_engine #(
  parameter int unsigned FrameBufLen = kfd_pkg::FRAME_BUF_LEN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [kfd_pkg::REQ_W-1:0]    req_type_i,
  input  logic [kfd_pkg::BYTE_W-1:0]   rx_byte_i,
  input  logic [kfd_pkg::MINLEN_W-1:0] min_frame_len_i,
  input  logic [kfd_pkg::TICKS_W-1:0]  timeout_ticks_i,
  output kfd_pkg::kfd_res_t            res_o
);
  import kfd_pkg::*;

  localparam int unsigned CntW = $clog2(FrameBufLen + 1);
  localparam logic [CntW-1:0] BufFull = CntW'(FrameBufLen);

  localparam logic [1:0] MODE_HUNT  = 2'd0;
  localparam logic [1:0] MODE_CMD   = 2'd1;
  localparam logic [1:0] MODE_DATA  = 2'd2;
  localparam logic [1:0] MODE_TRANS = 2'd3;

  logic [1:0]         mode_q, mode_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [BYTE_W-1:0]  first_q, first_d;
  logic [BYTE_W-1:0]  second_q, second_d;
  logic [TICKS_W-1:0] sil_q, sil_d;

  logic [TICKS_W-1:0] sil_inc;
  logic [BYTE_W-1:0]  unesc;
  logic               full;
  logic               long_enough;
  kfd_res_t           res;

  assign sil_inc     = (sil_q == '1) ? sil_q : sil_q + 1'b1;
  assign full        = cnt_q >= BufFull;
  assign long_enough = MINLEN_W'(cnt_q) >= min_frame_len_i;

  // Undo transposed escapes; unknown escapes pass through
  always_comb begin
    unesc = rx_byte_i;
    if (rx_byte_i == CH_TFEND) begin
      unesc = CH_FEND;
    end else if (rx_byte_i == CH_TFESC) begin
      unesc = CH_FESC;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    cmd_d    = cmd_q;
    first_d  = first_q;
    second_d = second_q;
    sil_d    = sil_q;
    res      = '0;

    case (req_type_i)
      REQ_ERR: begin
        mode_d   = MODE_HUNT;
        cnt_d    = '0;
        sil_d    = '0;
        res.valid = 1'b1;
        res.kind  = KIND_LINE;
      end
      REQ_TICK: begin
        // Count silence inside a frame, abort when it lasts too long
        if (mode_q != MODE_HUNT) begin
          sil_d = sil_inc;
          if (sil_inc >= timeout_ticks_i) begin
            mode_d = MODE_HUNT;
            cnt_d  = '0;
            sil_d  = '0;
            if (cnt_q != '0) begin
              res.valid = 1'b1;
              res.kind  = KIND_TIMEOUT;
            end
          end
        end
      end
      REQ_BYTE: begin
        sil_d = '0;
        case (mode_q)
          MODE_HUNT: begin
            if (rx_byte_i == CH_FEND) begin
              mode_d = MODE_CMD;
              cnt_d  = '0;
            end
          end
          MODE_CMD: begin
            if (rx_byte_i != CH_FEND) begin
              if (rx_byte_i[7:4] != 4'h0) begin
                // Other channel: drop the frame
                mode_d = MODE_HUNT;
              end else begin
                cmd_d    = rx_byte_i[3:0];
                cnt_d    = '0;
                first_d  = '0;
                second_d = '0;
                mode_d   = MODE_DATA;
              end
            end
          end
          MODE_TRANS: begin
            mode_d = MODE_DATA;
            // Saturated buffer drops the escaped byte
            if (!full) begin
              if (cnt_q == '0) begin
                first_d = unesc;
              end else if (cnt_q == CntW'(1)) begin
                second_d = unesc;
              end
              cnt_d = cnt_q + 1'b1;
              if (cmd_q == '0) begin
                res.valid     = 1'b1;
                res.kind      = KIND_DATA;
                res.data_byte = unesc;
              end
            end
          end
          default: begin
            if (rx_byte_i == CH_FESC) begin
              mode_d = MODE_TRANS;
            end else if (rx_byte_i == CH_FEND || full) begin
              // Close the frame; a full buffer also drops the rest of it
              if (cmd_q == '0) begin
                res.valid = 1'b1;
                res.kind  = long_enough ? KIND_GOOD : KIND_SHORT;
              end else if (cmd_q <= 4'd6 && cnt_q != '0) begin
                res.valid        = 1'b1;
                res.kind         = KIND_CMD;
                res.command_code = cmd_q;
                res.first_value  = first_q;
                res.second_value = second_q;
              end
              cnt_d    = '0;
              first_d  = '0;
              second_d = '0;
              mode_d   = (rx_byte_i == CH_FEND) ? MODE_CMD : MODE_HUNT;
            end else begin
              if (cnt_q == '0) begin
                first_d = rx_byte_i;
              end else if (cnt_q == CntW'(1)) begin
                second_d = rx_byte_i;
              end
              cnt_d = cnt_q + 1'b1;
              if (cmd_q == '0) begin
                res.valid     = 1'b1;
                res.kind      = KIND_DATA;
                res.data_byte = rx_byte_i;
              end
            end
          end
        endcase
      end
      default: begin
        // Unused request type: no effect
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_HUNT;
      cnt_q    <= '0;
      cmd_q    <= '0;
      first_q  <= '0;
      second_q <= '0;
      sil_q    <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      cnt_q    <= cnt_d;
      cmd_q    <= cmd_d;
      first_q  <= first_d;
      second_q <= second_d;
      sil_q    <= sil_d;
    end
  end

  assign res_o = res;

endmodule

[design/kiss_frame_deframer.sv]
// Top level of the KISS frame deframer: config registers, output register.
// Depends on kfd_pkg, kfd_in_reg and kfd_engine.
//
//  channel   dir  tdata                                    tuser
//  s_axis    in   [7:0] rx_byte                            [1:0] req_type
//  m_axis    out  [7:0] data_byte [11:8] command_code      [2:0] kind
//                 [19:12] first_value [27:20] second_value
//  cfg       in   cfg_we_i / cfg_idx_i / cfg_data_i, write only
//
// A result shows on m_axis after its transaction is accepted: the item is
// held in the input register, then passes through the engine into the output
// register once the output register is free to take it.
// One transaction is accepted per cycle; the output register stalls the
// engine only while a result waits for m_axis_tready.
// Reset clears the framing state to hunt and loads the register defaults;
// there is no clearing pass.
module kiss_frame_deframer #(
  parameter int unsigned FrameBufLen = kfd_pkg::FRAME_BUF_LEN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [kfd_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic [kfd_pkg::REQ_W-1:0]      s_axis_tuser,  // [1:0] req_type
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] data_byte, [11:8] command_code, [19:12] first_value,
  // [27:20] second_value, [31:28] zero
  output logic [kfd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  output logic [kfd_pkg::KIND_W-1:0]     m_axis_tuser,  // [2:0] kind
  input  logic                           cfg_we_i,
  input  logic [kfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kfd_pkg::TICKS_W-1:0]    cfg_data_i
);
  import kfd_pkg::*;

  logic [MINLEN_W-1:0] min_len_q;
  logic [TICKS_W-1:0]  timeout_q;

  logic              item_valid;
  logic [REQ_W-1:0]  req_type;
  logic [BYTE_W-1:0] rx_byte;
  logic              out_free;
  logic              step;
  kfd_res_t          res;

  logic              m_valid_q, m_valid_d;
  logic [KIND_W-1:0] kind_q;
  logic [BYTE_W-1:0] data_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [BYTE_W-1:0] first_q;
  logic [BYTE_W-1:0] second_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_FRAME_LEN_RST;
      timeout_q <= TIMEOUT_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_FRAME_LEN: min_len_q <= cfg_data_i[MINLEN_W-1:0];
        CFG_TIMEOUT_TICKS: timeout_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Advance the held item whenever the result register can take a result
  assign out_free = !m_valid_q || m_axis_tready;
  assign step     = item_valid && out_free;

  kfd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .advance_i    (step),
    .item_valid_o (item_valid),
    .req_type_o   (req_type),
    .rx_byte_o    (rx_byte)
  );

  kfd_engine #(
    .FrameBufLen(FrameBufLen)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .req_type_i     (req_type),
    .rx_byte_i      (rx_byte),
    .min_frame_len_i(min_len_q),
    .timeout_ticks_i(timeout_q),
    .res_o          (res)
  );

  // Result register
  always_comb begin
    m_valid_d = m_valid_q;
    if (step) begin
      m_valid_d = res.valid;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      kind_q   <= res.kind;
      data_q   <= res.data_byte;
      cmd_q    <= res.command_code;
      first_q  <= res.first_value;
      second_q <= res.second_value;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {4'h0, second_q, first_q, cmd_q, data_q};

endmodule

[design/kfd_checker.sv]
// Port-level checks of the KISS frame deframer, bound to the top level.
// Depends on kfd_pkg and kiss_frame_deframer.
module kfd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [kfd_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [kfd_pkg::KIND_W-1:0]    m_axis_tuser
);
  import kfd_pkg::*;

  // A stalled result holds
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Only defined kinds leave the block
  a_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= KIND_TIMEOUT)
    else $error("undefined result kind");

  // Command fields stay zero outside command results, padding always zero
  a_cmd_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_CMD |-> m_axis_tdata[31:8] == '0)
    else $error("command fields set outside a command result");

  // Data byte is zero on every result but a data byte
  a_data_field : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tdata[7:0] == '0)
    else $error("data byte set outside a data result");

endmodule

bind kiss_frame_deframer kfd_checker u_kfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
